/* rtl/core/tefc_pkg.sv */
`default_nettype none
package tefc_pkg;

  typedef enum logic [2:0] {
    FMT_F32  = 3'd0,
    FMT_F16  = 3'd1,
    FMT_BF16 = 3'd2,
    FMT_BOOL = 3'd3,
    FMT_I32  = 3'd4,
    FMT_E8M0 = 3'd5,
    FMT_E4M3 = 3'd6,
    FMT_E5M2 = 3'd7
  } fmt_e;

  localparam logic [1:0] RegFormat   = 2'd0;
  localparam logic [1:0] RegSentinel = 2'd1;
  localparam logic [31:0] SentinelReset = 32'hFFFF_FFFF;
  localparam logic [7:0]  BoolPad = 8'hA5;
  localparam logic [31:0] QuietNan = 32'h7FC0_0000;

  // result of the first stage: everything that does not need a shifter is
  // finished here, the rest hands a significand and shift amount onward
  typedef struct packed {
    logic        done;      // result complete in res
    logic [31:0] res;
    logic        flag;
    logic [31:0] sig;       // operand for stage two shifter
    logic [5:0]  rsh;       // right shift amount (rne), or left for lsh
    logic        lsh;       // left shift (no rounding)
    logic        rne;       // round nearest even after shift
    logic        neg;       // negate result (int32 encode); also marks int32 decode
    logic [31:0] base;      // added after rounding
    logic [31:0] lim;       // clamp limit on added value (0 = none)
    logic        sat;
    logic [7:0]  sgn;       // ORed on top
  } s1_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
    logic        flag;
    logic [31:0] val;
    logic        neg;
    logic [31:0] base;
    logic [31:0] lim;
    logic        sat;
    logic [7:0]  sgn;
    logic        i2f;       // int32 decode: post-normalise
    logic [31:0] i2f_s;
    logic [7:0]  i2f_e;
  } s2_t;

  function automatic logic [4:0] msb32(input logic [31:0] x);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 1; i < 32; i++) if (x[i]) p = 5'(i);
    return p;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/tefc_if.sv */
`default_nettype none
interface tefc_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] in_value;
  modport source (output valid, req_type, in_value, input ready);
  modport sink   (input valid, req_type, in_value, output ready);
endinterface

interface tefc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;
  logic        not_representable;
  modport source (output valid, result_bits, not_representable, input ready);
  modport sink   (input valid, result_bits, not_representable, output ready);
endinterface
`default_nettype wire

/* rtl/core/tensor_element_format_codec_unit.sv */
`default_nettype none
// Channel   | dir | payload
// in_if     | in  | req_type, in_value
// out_if    | out | result_bits, not_representable
// apb       | cfg | reg 0 element_format @0x0, reg 1 padding_sentinel_bits @0x4
//
// One word per cycle when not stalled by out_if.ready. Three register stages:
// classify/setup, shift with round-to-nearest-even, add/clamp/pack. A stall
// holds every stage; a bubble stage fills while downstream waits.
// Reset clears valid bits and loads register reset values.
module tensor_element_format_codec_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  tefc_in_if.sink          in_if,
  tefc_out_if.source       out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  tefc_pkg::fmt_e fmt_q;
  logic [31:0] sent_q;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= tefc_pkg::FMT_F32;
      sent_q <= tefc_pkg::SentinelReset;
    end else if (wr) begin
      if (paddr[2] == tefc_pkg::RegFormat[0]) fmt_q <= tefc_pkg::fmt_e'(pwdata[2:0]);
      else sent_q <= pwdata;
    end
  end

  always_comb begin
    if (paddr[2] == tefc_pkg::RegSentinel[0]) prdata = sent_q;
    else prdata = {29'd0, fmt_q};
  end

  // pipeline enables
  logic v1_q, v2_q, v3_q, en1, en2, en3;
  assign en3 = !v3_q || out_if.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_if.ready = en1;

  tefc_pkg::s1_t s1_d, s1_q;
  tefc_pkg::s2_t s2_d, s2_q;
  logic [31:0] r3_q;
  logic        f3_q;

  tefc_front u_front (
    .dec_i (in_if.req_type),
    .v_i   (in_if.in_value),
    .fmt_i (fmt_q),
    .sent_i(sent_q),
    .s1_o  (s1_d)
  );

  // stage two: shift and round
  logic [31:0] q, rem, half, msk;
  logic        inc, idec;
  always_comb begin
    idec = s1_q.neg && (s1_q.sgn != 0 || s1_q.base[31:8] == 0) && s1_q.base != 0
           && !s1_q.sat && s1_q.lim == 0 && s1_q.base[7:0] >= 8'd127;
    q = '0; rem = '0; half = '0; msk = '0; inc = 1'b0;
    if (s1_q.lsh) q = s1_q.sig << s1_q.rsh[4:0];
    else if (s1_q.rsh >= 6'd32) q = 32'd0;
    else begin
      q = s1_q.sig >> s1_q.rsh[4:0];
      msk = (32'd1 << s1_q.rsh[4:0]) - 32'd1;
      rem = s1_q.sig & msk;
      half = (s1_q.rsh == 0) ? 32'd0 : (32'd1 << (s1_q.rsh[4:0] - 5'd1));
      inc = s1_q.rne && s1_q.rsh != 0 && (rem > half || (rem == half && q[0]));
    end
    s2_d = '0;
    s2_d.done = s1_q.done;
    s2_d.res  = s1_q.res;
    s2_d.flag = s1_q.flag;
    s2_d.val  = q + {31'd0, inc};
    s2_d.base = s1_q.base;
    s2_d.lim  = s1_q.lim;
    s2_d.sat  = s1_q.sat;
    s2_d.sgn  = s1_q.sgn;
    s2_d.i2f  = idec;
    s2_d.neg  = s1_q.neg && !idec;
    s2_d.i2f_e = s1_q.base[7:0];
    s2_d.i2f_s = s2_d.val;
  end

  // stage three: add, clamp, pack
  logic [31:0] r3_d, sum;
  logic [7:0]  ie;
  always_comb begin
    sum = s2_q.base + s2_q.val;
    ie = s2_q.i2f_e;
    r3_d = s2_q.res;
    if (!s2_q.done) begin
      if (s2_q.i2f) begin
        if (s2_q.i2f_s[24]) ie = ie + 8'd1;
        r3_d = {s2_q.sgn[7], ie, s2_q.i2f_s[24] ? s2_q.i2f_s[23:1] : s2_q.i2f_s[22:0]};
      end else if (s2_q.neg) r3_d = 32'd0 - s2_q.val;
      else if (s2_q.sat) begin
        r3_d = {24'd0, s2_q.sgn[7],
                (sum > s2_q.lim) ? s2_q.lim[6:0] : sum[6:0]};
      end else if (s2_q.lim != 0) begin
        // fp16 normal: val = exp:mant rounded
        r3_d = s2_q.base | ((s2_q.val >= s2_q.lim) ? s2_q.lim : s2_q.val);
      end else r3_d = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_if.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) begin
      r3_q <= r3_d;
      f3_q <= s2_q.flag;
    end
  end

  assign out_if.valid = v3_q;
  assign out_if.result_bits = r3_q;
  assign out_if.not_representable = f3_q;

endmodule
`default_nettype wire

/* rtl/core/tefc_front.sv */
`default_nettype none
// stage one decode: classify, finish the trivial cases, set up the shifter
module tefc_front (
  input  wire logic                   dec_i,
  input  wire logic [31:0]            v_i,
  input  wire tefc_pkg::fmt_e         fmt_i,
  input  wire logic [31:0]            sent_i,
  output tefc_pkg::s1_t               s1_o
);
  logic [7:0]  e;
  logic [22:0] m;
  logic        sg;
  logic [4:0]  p;
  logic [7:0]  byt;
  logic [15:0] hw;
  logic [32:0] bft;
  logic [31:0] mag;
  int          ex, he, r;

  always_comb begin
    e  = v_i[30:23];
    m  = v_i[22:0];
    sg = v_i[31];
    byt = v_i[7:0];
    hw  = v_i[15:0];
    mag = v_i[31] ? (32'd0 - v_i) : v_i;
    p  = 5'd0;
    bft = 33'd0;
    ex = 0; he = 0; r = 0;
    s1_o = '0;
    if (!dec_i) begin
      unique case (fmt_i)
        tefc_pkg::FMT_F32: begin s1_o.done = 1'b1; s1_o.res = v_i; end
        tefc_pkg::FMT_BF16: begin
          s1_o.done = 1'b1;
          if (e != 8'hFF) bft = {1'b0, v_i} + 33'h7FFF + {32'd0, v_i[16]};
          else bft = {1'b0, v_i | (m != 0 ? 32'h0040_0000 : 32'd0)};
          s1_o.res = {16'd0, bft[31:16]};
        end
        tefc_pkg::FMT_BOOL: begin
          s1_o.done = 1'b1;
          s1_o.res = (v_i == sent_i) ? {24'd0, tefc_pkg::BoolPad}
                   : {31'd0, (v_i[30:0] != 0)};
        end
        tefc_pkg::FMT_I32: begin
          if (e == 8'hFF) begin s1_o.done = 1'b1; s1_o.flag = 1'b1; end
          else if (e < 8'd127) s1_o.done = 1'b1;
          else if (e >= 8'd158) begin
            s1_o.done = 1'b1;
            if (v_i == 32'hCF00_0000) s1_o.res = 32'h8000_0000;
            else s1_o.flag = 1'b1;
          end else begin
            s1_o.sig = {8'd0, 1'b1, m};
            s1_o.neg = sg;
            if (e >= 8'd150) begin s1_o.lsh = 1'b1; s1_o.rsh = 6'(e - 8'd150); end
            else s1_o.rsh = 6'(8'd150 - e);
          end
        end
        tefc_pkg::FMT_E8M0: begin
          s1_o.done = 1'b1;
          if (v_i == sent_i) s1_o.res = 32'd0;
          else if (sg || v_i[30:0] == 0 || e == 8'hFF) s1_o.res = 32'd255;
          else if (e == 0) s1_o.res = {31'd0, ((m & (m - 23'd1)) != 0) && m[22]};
          else if (m == 0) s1_o.res = {24'd0, e};
          else s1_o.res = (e == 8'hFF) ? 32'd255 : {23'd0, {1'b0, e} + 9'd1};
          if (e == 8'hFE && m != 0 && !sg && v_i != sent_i) s1_o.res = 32'd255;
        end
        tefc_pkg::FMT_F16: begin
          he = int'(e) - 112;
          s1_o.sgn = 8'd0;
          if (e == 8'hFF) begin
            s1_o.done = 1'b1;
            s1_o.res = {16'd0, sg, (m != 0) ? 15'h7E00 : 15'h7C00};
          end else if (he >= 31) begin
            s1_o.done = 1'b1; s1_o.res = {16'd0, sg, 15'h7C00};
          end else if (he <= 0) begin
            s1_o.res = {16'd0, sg, 15'd0};
            if (he < -10) s1_o.done = 1'b1;
            else begin
              s1_o.sig = {8'd0, 1'b1, m};
              s1_o.rsh = 6'(14 - he);
              s1_o.rne = 1'b1;
              s1_o.base = {16'd0, sg, 15'd0};
            end
          end else begin
            // normal: rounding may carry into the exponent; 0x7C00 is inf
            s1_o.sig = {4'd0, 5'(he), m};
            s1_o.rsh = 6'd13;
            s1_o.rne = 1'b1;
            s1_o.base = {16'd0, sg, 15'd0};
            s1_o.lim = 32'h7C00;
          end
        end
        default: begin // fp8 encode
          if (e == 8'hFF) begin
            s1_o.done = 1'b1;
            s1_o.res = (m != 0) ? 32'hFF
                     : {24'd0, sg, (fmt_i == tefc_pkg::FMT_E4M3) ? 7'h7E : 7'h7B};
          end else if (e == 0 && m == 0) begin
            s1_o.done = 1'b1; s1_o.res = {24'd0, sg, 7'd0};
          end else begin
            s1_o.sat = 1'b1;
            s1_o.sgn = {sg, 7'd0};
            s1_o.lim = (fmt_i == tefc_pkg::FMT_E4M3) ? 32'h7E : 32'h7B;
            ex = (e != 0) ? int'(e) - 127 : -126;
            s1_o.sig = {8'd0, (e != 0), m};
            s1_o.rne = 1'b1;
            if (ex > 16) begin s1_o.done = 1'b1; s1_o.res = {24'd0, sg, s1_o.lim[6:0]}; end
            else if (fmt_i == tefc_pkg::FMT_E4M3) begin
              if (ex >= -6) begin
                s1_o.base = 32'((ex + 6) << 3); s1_o.rsh = 6'd20;
              end else begin
                r = 14 - ex; s1_o.rsh = (r >= 25) ? 6'd32 : 6'(r);
              end
            end else begin
              if (ex >= -14) begin
                s1_o.base = 32'((ex + 14) << 2); s1_o.rsh = 6'd21;
              end else begin
                r = 7 - ex; s1_o.rsh = (r >= 25) ? 6'd32 : 6'(r);
              end
            end
          end
        end
      endcase
    end else begin
      s1_o.done = 1'b1;
      unique case (fmt_i)
        tefc_pkg::FMT_F32: s1_o.res = v_i;
        tefc_pkg::FMT_BF16: s1_o.res = {hw, 16'd0};
        tefc_pkg::FMT_BOOL:
          s1_o.res = (byt == tefc_pkg::BoolPad) ? sent_i
                   : ((byt != 0) ? 32'h3F80_0000 : 32'd0);
        tefc_pkg::FMT_E8M0:
          s1_o.res = (byt == 8'hFF) ? tefc_pkg::QuietNan
                   : ((byt == 0) ? 32'h0040_0000 : {1'b0, byt, 23'd0});
        tefc_pkg::FMT_F16: begin
          if (hw[14:10] == 0) begin
            p = tefc_pkg::msb32({22'd0, hw[9:0]});
            if (hw[9:0] == 0) s1_o.res = {hw[15], 31'd0};
            else s1_o.res = {hw[15], 8'({3'd0, p} + 8'd103),
                             23'(({22'd0, hw[9:0]} & ((32'd1 << p) - 32'd1)) << (23 - p))};
          end else if (hw[14:10] == 5'h1F) s1_o.res = {hw[15], 8'hFF, hw[9:0], 13'd0};
          else s1_o.res = {hw[15], 8'({3'd0, hw[14:10]} + 8'd112), hw[9:0], 13'd0};
        end
        tefc_pkg::FMT_E4M3: begin
          if (byt[6:0] == 7'h7F) s1_o.res = {byt[7], 31'h7FC0_0000};
          else if (byt[6:3] == 0) begin
            p = tefc_pkg::msb32({29'd0, byt[2:0]});
            if (byt[2:0] == 0) s1_o.res = {byt[7], 31'd0};
            else s1_o.res = {byt[7], 8'({3'd0, p} + 8'd118),
                             23'(({29'd0, byt[2:0]} & ((32'd1 << p) - 32'd1)) << (23 - p))};
          end else s1_o.res = {byt[7], 8'({4'd0, byt[6:3]} + 8'd120), byt[2:0], 20'd0};
        end
        tefc_pkg::FMT_E5M2: begin
          if (byt[6:2] == 5'h1F)
            s1_o.res = {byt[7], (byt[1:0] != 0) ? 31'h7FC0_0000 : 31'h7F80_0000};
          else if (byt[6:2] == 0) begin
            p = tefc_pkg::msb32({30'd0, byt[1:0]});
            if (byt[1:0] == 0) s1_o.res = {byt[7], 31'd0};
            else s1_o.res = {byt[7], 8'({3'd0, p} + 8'd111),
                             23'(({30'd0, byt[1:0]} & ((32'd1 << p) - 32'd1)) << (23 - p))};
          end else s1_o.res = {byt[7], 8'({3'd0, byt[6:2]} + 8'd112), byt[1:0], 21'd0};
        end
        default: begin // int32 decode: normalise in the next stages
          if (v_i == 0) s1_o.res = 32'd0;
          else begin
            s1_o.done = 1'b0;
            p = tefc_pkg::msb32(mag);
            s1_o.sgn = {v_i[31], 7'd0};
            s1_o.sig = mag;
            s1_o.base = {24'd0, 8'({3'd0, p} + 8'd127)};
            if (p <= 5'd23) begin s1_o.lsh = 1'b1; s1_o.rsh = 6'(5'd23 - p); end
            else begin s1_o.rne = 1'b1; s1_o.rsh = 6'(p - 5'd23); end
            s1_o.neg = 1'b1; // marks int decode in stage two
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire
